### rtl/quaternion_trs_matrix_macros.svh
// Assertion macros for the quaternion TRS matrix builder
`ifndef QUATERNION_TRS_MATRIX_MACROS_SVH
`define QUATERNION_TRS_MATRIX_MACROS_SVH

// Same-cycle implication, checked outside reset
`define QTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define QTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qtm_pkg.sv
// Types, widths and constants for the quaternion TRS matrix builder
package qtm_pkg;

  localparam int QW       = 16;                 // Q2.14 quaternion component
  localparam int SW       = 16;                 // Q8.8 scale
  localparam int EW       = 32;                 // Q16.16 element
  localparam int PW       = 2 * QW;             // quaternion product, Q.28
  localparam int RW       = PW + 3;             // rotation term, Q.28 with headroom
  localparam int MW       = RW + SW;            // term times scale, Q.36
  localparam int AW       = MW + 1;             // rounding sum
  localparam int DROP     = 20;                 // fraction bits dropped to reach Q16.16
  localparam int NUM_ROWS = 4;

  typedef logic signed [QW-1:0] quat_t;
  typedef logic signed [SW-1:0] scale_t;
  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [RW-1:0] rot_t;
  typedef logic signed [MW-1:0] mul_t;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic [$clog2(NUM_ROWS)-1:0] row_t;

  localparam row_t ROW_0     = row_t'(0);
  localparam row_t ROW_1     = row_t'(1);
  localparam row_t ROW_2     = row_t'(2);
  localparam row_t ROW_TRANS = row_t'(NUM_ROWS - 1);

  localparam rot_t ONE_Q28   = rot_t'(1) <<< 28;
  localparam acc_t RND_HALF  = acc_t'(1) <<< (DROP - 1);

  // Side data that travels with a row down the pipeline
  typedef struct packed {
    row_t   row;
    scale_t scl;
    elem_t  tx;
    elem_t  ty;
    elem_t  tz;
  } side_t;

  // 2*(a+b) in Q.28
  function automatic rot_t dbl_sum(input prod_t a, input prod_t b);
    return (rot_t'(a) + rot_t'(b)) <<< 1;
  endfunction

  // 2*(a-b) in Q.28
  function automatic rot_t dbl_diff(input prod_t a, input prod_t b);
    return (rot_t'(a) - rot_t'(b)) <<< 1;
  endfunction

  // 1 - 2*(a+b) in Q.28
  function automatic rot_t one_minus(input prod_t a, input prod_t b);
    return ONE_Q28 - ((rot_t'(a) + rot_t'(b)) <<< 1);
  endfunction

endpackage

### rtl/quaternion_trs_matrix.sv
// Quaternion TRS matrix builder: rotation, per-row scale and translation rows
//
//   channel | ports                              | transfer
//   --------+------------------------------------+-----------------------------
//   in      | in_quat_*, in_scale_*, in_trans_*  | in_valid & in_ready, 1 item
//   out     | out_row_index, out_elem_*, flags   | out_valid & out_ready, 1 row
//
// One item gives four rows, rows 0 to 3 in order, one row per cycle while the output
// flows, so an item is held until its last row issues; the single result port sets that.
// After the input transfer the first row passes the hold register, products, terms,
// scaling, then rounding into the output register.
// Reset clears the valid bits and the row count only. A stall on out freezes every
// stage at once; the next item is taken in the cycle its predecessor's last row issues.
`include "quaternion_trs_matrix_macros.svh"

module quaternion_trs_matrix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qtm_pkg::quat_t       in_quat_w,
  input  qtm_pkg::quat_t       in_quat_x,
  input  qtm_pkg::quat_t       in_quat_y,
  input  qtm_pkg::quat_t       in_quat_z,
  input  qtm_pkg::scale_t      in_scale_x,
  input  qtm_pkg::scale_t      in_scale_y,
  input  qtm_pkg::scale_t      in_scale_z,
  input  qtm_pkg::elem_t       in_trans_x,
  input  qtm_pkg::elem_t       in_trans_y,
  input  qtm_pkg::elem_t       in_trans_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qtm_pkg::row_t        out_row_index,
  output qtm_pkg::elem_t       out_elem_0,
  output qtm_pkg::elem_t       out_elem_1,
  output qtm_pkg::elem_t       out_elem_2,
  output logic                 out_saturated,
  output logic                 out_last_row
);

  // Item hold register and row sequencer
  logic            item_vld_r;
  qtm_pkg::quat_t  qw_r, qx_r, qy_r, qz_r;
  qtm_pkg::scale_t sx_r, sy_r, sz_r;
  qtm_pkg::elem_t  tx_r, ty_r, tz_r;
  qtm_pkg::row_t   row_cnt_r;

  // Pipeline stages
  logic            s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  qtm_pkg::side_t  s1_side_r, s2_side_r, s3_side_r;
  qtm_pkg::side_t  s1_side_nxt;
  qtm_pkg::prod_t  p_xx_r, p_yy_r, p_zz_r, p_xy_r, p_xz_r, p_yz_r, p_wx_r, p_wy_r, p_wz_r;
  qtm_pkg::rot_t   rot_nxt [3];
  qtm_pkg::rot_t   rot_r   [3];
  qtm_pkg::mul_t   mul_r   [3];
  qtm_pkg::acc_t   acc     [3];
  qtm_pkg::elem_t  rnd     [3];
  logic [2:0]      clip;
  qtm_pkg::elem_t  e_nxt   [3];
  logic            sat_nxt;

  qtm_pkg::row_t   out_row_r;
  qtm_pkg::elem_t  out_e_r [3];
  logic            out_sat_r;

  logic adv;
  logic issue;
  logic in_xfer;

  // Whole pipeline moves when the output register is free or being drained
  assign adv      = !out_vld_r || out_ready;
  assign issue    = adv && item_vld_r;
  assign in_ready = !item_vld_r || (issue && (row_cnt_r == qtm_pkg::ROW_TRANS));
  assign in_xfer  = in_valid && in_ready;

  // Hold the item and step through its rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      row_cnt_r  <= qtm_pkg::ROW_0;
    end else begin
      if (in_xfer) begin
        item_vld_r <= 1'b1;
        row_cnt_r  <= qtm_pkg::ROW_0;
      end else if (issue && (row_cnt_r == qtm_pkg::ROW_TRANS)) begin
        item_vld_r <= 1'b0;
      end else if (issue) begin
        row_cnt_r  <= row_cnt_r + qtm_pkg::row_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      qw_r <= in_quat_w;
      qx_r <= in_quat_x;
      qy_r <= in_quat_y;
      qz_r <= in_quat_z;
      sx_r <= in_scale_x;
      sy_r <= in_scale_y;
      sz_r <= in_scale_z;
      tx_r <= in_trans_x;
      ty_r <= in_trans_y;
      tz_r <= in_trans_z;
    end
  end

  // Pick the scale of the row being issued
  always_comb begin
    s1_side_nxt.row = row_cnt_r;
    s1_side_nxt.tx  = tx_r;
    s1_side_nxt.ty  = ty_r;
    s1_side_nxt.tz  = tz_r;
    case (row_cnt_r)
      qtm_pkg::ROW_0: s1_side_nxt.scl = sx_r;
      qtm_pkg::ROW_1: s1_side_nxt.scl = sy_r;
      qtm_pkg::ROW_2: s1_side_nxt.scl = sz_r;
      default:        s1_side_nxt.scl = '0;
    endcase
  end

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= item_vld_r;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  // Stage 1: quaternion products, Q.28
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= s1_side_nxt;
      p_xx_r    <= qtm_pkg::prod_t'(qx_r) * qtm_pkg::prod_t'(qx_r);
      p_yy_r    <= qtm_pkg::prod_t'(qy_r) * qtm_pkg::prod_t'(qy_r);
      p_zz_r    <= qtm_pkg::prod_t'(qz_r) * qtm_pkg::prod_t'(qz_r);
      p_xy_r    <= qtm_pkg::prod_t'(qx_r) * qtm_pkg::prod_t'(qy_r);
      p_xz_r    <= qtm_pkg::prod_t'(qx_r) * qtm_pkg::prod_t'(qz_r);
      p_yz_r    <= qtm_pkg::prod_t'(qy_r) * qtm_pkg::prod_t'(qz_r);
      p_wx_r    <= qtm_pkg::prod_t'(qw_r) * qtm_pkg::prod_t'(qx_r);
      p_wy_r    <= qtm_pkg::prod_t'(qw_r) * qtm_pkg::prod_t'(qy_r);
      p_wz_r    <= qtm_pkg::prod_t'(qw_r) * qtm_pkg::prod_t'(qz_r);
    end
  end

  // Stage 2: rotation terms of the current row
  always_comb begin
    case (s1_side_r.row)
      qtm_pkg::ROW_0: begin
        rot_nxt[0] = qtm_pkg::one_minus(p_yy_r, p_zz_r);
        rot_nxt[1] = qtm_pkg::dbl_sum(p_xy_r, p_wz_r);
        rot_nxt[2] = qtm_pkg::dbl_diff(p_xz_r, p_wy_r);
      end
      qtm_pkg::ROW_1: begin
        rot_nxt[0] = qtm_pkg::dbl_diff(p_xy_r, p_wz_r);
        rot_nxt[1] = qtm_pkg::one_minus(p_xx_r, p_zz_r);
        rot_nxt[2] = qtm_pkg::dbl_sum(p_yz_r, p_wx_r);
      end
      qtm_pkg::ROW_2: begin
        rot_nxt[0] = qtm_pkg::dbl_sum(p_xz_r, p_wy_r);
        rot_nxt[1] = qtm_pkg::dbl_diff(p_yz_r, p_wx_r);
        rot_nxt[2] = qtm_pkg::one_minus(p_xx_r, p_yy_r);
      end
      default: begin
        rot_nxt[0] = '0;
        rot_nxt[1] = '0;
        rot_nxt[2] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r <= s1_side_r;
      rot_r[0]  <= rot_nxt[0];
      rot_r[1]  <= rot_nxt[1];
      rot_r[2]  <= rot_nxt[2];
    end
  end

  // Stage 3: scale each term, exact Q.36
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r <= s2_side_r;
      for (int i = 0; i < 3; i++) begin
        mul_r[i] <= qtm_pkg::mul_t'(rot_r[i]) * qtm_pkg::mul_t'(s2_side_r.scl);
      end
    end
  end

  // Stage 4: round half up to Q16.16 and clip to the 32-bit range; the translation row passes through
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = (qtm_pkg::acc_t'(mul_r[i]) + qtm_pkg::RND_HALF) >>> qtm_pkg::DROP;
      clip[i] = (acc[i][qtm_pkg::AW-1:qtm_pkg::EW-1] != '0) &&
                (acc[i][qtm_pkg::AW-1:qtm_pkg::EW-1] != '1);
      if (!clip[i]) begin
        rnd[i] = acc[i][qtm_pkg::EW-1:0];
      end else if (acc[i][qtm_pkg::AW-1]) begin
        rnd[i] = {1'b1, {(qtm_pkg::EW-1){1'b0}}};
      end else begin
        rnd[i] = {1'b0, {(qtm_pkg::EW-1){1'b1}}};
      end
    end
    if (s3_side_r.row == qtm_pkg::ROW_TRANS) begin
      e_nxt[0] = s3_side_r.tx;
      e_nxt[1] = s3_side_r.ty;
      e_nxt[2] = s3_side_r.tz;
      sat_nxt  = 1'b0;
    end else begin
      e_nxt[0] = rnd[0];
      e_nxt[1] = rnd[1];
      e_nxt[2] = rnd[2];
      sat_nxt  = |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_r  <= s3_side_r.row;
      out_e_r[0] <= e_nxt[0];
      out_e_r[1] <= e_nxt[1];
      out_e_r[2] <= e_nxt[2];
      out_sat_r  <= sat_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_row_index = out_row_r;
  assign out_elem_0    = out_e_r[0];
  assign out_elem_1    = out_e_r[1];
  assign out_elem_2    = out_e_r[2];
  assign out_saturated = out_sat_r;
  assign out_last_row  = (out_row_r == qtm_pkg::ROW_TRANS);

  // Checks
  `QTM_ASSERT_NOW(a_no_take_mid_item, item_vld_r && (row_cnt_r != qtm_pkg::ROW_TRANS), !in_ready, "input taken before last row issued")
  `QTM_ASSERT_NOW(a_trans_not_clipped, out_valid && out_last_row, !out_saturated, "translation row flagged as clipped")
  `QTM_ASSERT_NEXT(a_row_follows, issue && (row_cnt_r != qtm_pkg::ROW_TRANS), item_vld_r && (row_cnt_r == $past(row_cnt_r) + qtm_pkg::row_t'(1)), "row sequence broken")

endmodule

### bench/tb_quaternion_trs_matrix.sv
// Self-checking bench for the quaternion TRS matrix builder
module tb_quaternion_trs_matrix;

  // One input item: rotation, per-row scale and translation
  typedef struct {
    qtm_pkg::quat_t  w, x, y, z;
    qtm_pkg::scale_t sx, sy, sz;
    qtm_pkg::elem_t  tx, ty, tz;
  } pose_t;

  // One matrix row as the block should emit it
  typedef struct {
    qtm_pkg::row_t  idx;
    qtm_pkg::elem_t e0, e1, e2;
    logic           sat;
    logic           last;
  } matrix_row_t;

  localparam longint          UNIT_Q28 = longint'(1) <<< 28;
  localparam longint          HALF_LSB = longint'(1) <<< (qtm_pkg::DROP - 1);
  localparam longint          ELEM_MAX = 64'sh7FFF_FFFF;
  localparam longint          ELEM_MIN = -(64'sh8000_0000);
  localparam qtm_pkg::quat_t  Q_ONE    = 16'sd16384;
  localparam qtm_pkg::quat_t  Q_COS45  = 16'sd11585;
  localparam qtm_pkg::scale_t S_ONE    = 16'sd256;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  qtm_pkg::quat_t  in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  qtm_pkg::scale_t in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  qtm_pkg::elem_t  in_trans_x = '0, in_trans_y = '0, in_trans_z = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  qtm_pkg::row_t   out_row_index;
  qtm_pkg::elem_t  out_elem_0, out_elem_1, out_elem_2;
  logic            out_saturated, out_last_row;

  matrix_row_t row_q[$];
  int          err_count = 0;
  int          items_sent = 0;
  int          rows_checked = 0;
  int          rx_wait = 0;
  bit          idle_en = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_trs_matrix u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_quat_w     (in_quat_w),
    .in_quat_x     (in_quat_x),
    .in_quat_y     (in_quat_y),
    .in_quat_z     (in_quat_z),
    .in_scale_x    (in_scale_x),
    .in_scale_y    (in_scale_y),
    .in_scale_z    (in_scale_z),
    .in_trans_x    (in_trans_x),
    .in_trans_y    (in_trans_y),
    .in_trans_z    (in_trans_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_elem_0    (out_elem_0),
    .out_elem_1    (out_elem_1),
    .out_elem_2    (out_elem_2),
    .out_saturated (out_saturated),
    .out_last_row  (out_last_row)
  );

  // Q.28 term times Q8.8 scale, rounded half up to Q16.16 and clipped
  function automatic qtm_pkg::elem_t scale_to_q16(input longint rot, input longint scl,
                                                  inout logic sat);
    longint r;
    r = (rot * scl + HALF_LSB) >>> qtm_pkg::DROP;
    if (r > ELEM_MAX) begin
      r = ELEM_MAX;
      sat = 1'b1;
    end else if (r < ELEM_MIN) begin
      r = ELEM_MIN;
      sat = 1'b1;
    end
    return qtm_pkg::elem_t'(r);
  endfunction

  // Work out the four rows of one item and queue them in order
  function automatic void build_matrix_rows(input pose_t p);
    longint      w, x, y, z;
    longint      rot[3][3];
    longint      scl[3];
    logic        sat;
    matrix_row_t r;
    w = p.w;
    x = p.x;
    y = p.y;
    z = p.z;
    rot[0][0] = UNIT_Q28 - 2 * (y * y + z * z);
    rot[0][1] = 2 * (x * y + w * z);
    rot[0][2] = 2 * (x * z - w * y);
    rot[1][0] = 2 * (x * y - w * z);
    rot[1][1] = UNIT_Q28 - 2 * (x * x + z * z);
    rot[1][2] = 2 * (y * z + w * x);
    rot[2][0] = 2 * (x * z + w * y);
    rot[2][1] = 2 * (y * z - w * x);
    rot[2][2] = UNIT_Q28 - 2 * (x * x + y * y);
    scl[0] = p.sx;
    scl[1] = p.sy;
    scl[2] = p.sz;
    for (int i = 0; i < 3; i++) begin
      sat   = 1'b0;
      r.idx = qtm_pkg::row_t'(i);
      r.e0  = scale_to_q16(rot[i][0], scl[i], sat);
      r.e1  = scale_to_q16(rot[i][1], scl[i], sat);
      r.e2  = scale_to_q16(rot[i][2], scl[i], sat);
      r.sat = sat;
      r.last = 1'b0;
      row_q.push_back(r);
    end
    // Translation row passes straight through
    r.idx  = qtm_pkg::ROW_TRANS;
    r.e0   = p.tx;
    r.e1   = p.ty;
    r.e2   = p.tz;
    r.sat  = 1'b0;
    r.last = 1'b1;
    row_q.push_back(r);
  endfunction

  function automatic pose_t make_pose(input qtm_pkg::quat_t w, x, y, z,
                                      input qtm_pkg::scale_t sx, sy, sz,
                                      input qtm_pkg::elem_t tx, ty, tz);
    pose_t p;
    p.w  = w;
    p.x  = x;
    p.y  = y;
    p.z  = z;
    p.sx = sx;
    p.sy = sy;
    p.sz = sz;
    p.tx = tx;
    p.ty = ty;
    p.tz = tz;
    return p;
  endfunction

  // Unit quaternion with random direction, scale mostly moderate
  function automatic pose_t random_unit_pose();
    real   a[4];
    real   n;
    pose_t p;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      a[i] = real'(int'($urandom_range(0, 32768)) - 16384);
      n = n + a[i] * a[i];
    end
    n = $sqrt(n);
    if (n < 1.0) begin
      p.w = Q_ONE;
      p.x = '0;
      p.y = '0;
      p.z = '0;
    end else begin
      p.w = qtm_pkg::quat_t'($rtoi(a[0] * 16384.0 / n));
      p.x = qtm_pkg::quat_t'($rtoi(a[1] * 16384.0 / n));
      p.y = qtm_pkg::quat_t'($rtoi(a[2] * 16384.0 / n));
      p.z = qtm_pkg::quat_t'($rtoi(a[3] * 16384.0 / n));
    end
    if ($urandom_range(0, 3) != 0) begin
      p.sx = qtm_pkg::scale_t'(int'($urandom_range(0, 1023)) - 512);
      p.sy = qtm_pkg::scale_t'(int'($urandom_range(0, 1023)) - 512);
      p.sz = qtm_pkg::scale_t'(int'($urandom_range(0, 1023)) - 512);
    end else begin
      p.sx = qtm_pkg::scale_t'($urandom);
      p.sy = qtm_pkg::scale_t'($urandom);
      p.sz = qtm_pkg::scale_t'($urandom);
    end
    p.tx = qtm_pkg::elem_t'($urandom);
    p.ty = qtm_pkg::elem_t'($urandom);
    p.tz = qtm_pkg::elem_t'($urandom);
    return p;
  endfunction

  // Every field drawn over its full range
  function automatic pose_t random_raw_pose();
    return make_pose(qtm_pkg::quat_t'($urandom), qtm_pkg::quat_t'($urandom),
                     qtm_pkg::quat_t'($urandom), qtm_pkg::quat_t'($urandom),
                     qtm_pkg::scale_t'($urandom), qtm_pkg::scale_t'($urandom),
                     qtm_pkg::scale_t'($urandom), qtm_pkg::elem_t'($urandom),
                     qtm_pkg::elem_t'($urandom), qtm_pkg::elem_t'($urandom));
  endfunction

  // Offer one item, hold it until the transfer, then queue its rows
  task automatic send_pose(input pose_t p);
    int gap;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_quat_w  <= p.w;
    in_quat_x  <= p.x;
    in_quat_y  <= p.y;
    in_quat_z  <= p.z;
    in_scale_x <= p.sx;
    in_scale_y <= p.sy;
    in_scale_z <= p.sz;
    in_trans_x <= p.tx;
    in_trans_y <= p.ty;
    in_trans_z <= p.tz;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    build_matrix_rows(p);
    items_sent++;
  endtask

  // Drop valid and wait for every queued row to come out
  task automatic drain_rows();
    in_valid <= 1'b0;
    do @(posedge clk); while (row_q.size() != 0);
  endtask

  task automatic test_identity_and_extremes();
    send_pose(make_pose(Q_ONE, 0, 0, 0, S_ONE, S_ONE, S_ONE, 0, 0, 0));
    send_pose(make_pose(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                        16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_pose(make_pose(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh8000, 16'sh8000, 16'sh8000,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Far from unit length with mixed signs
    send_pose(make_pose(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                        16'sh8000, 16'sh7FFF, 16'sh8000, -1, 1, 0));
  endtask

  task automatic test_axis_rotations();
    send_pose(make_pose(Q_COS45, Q_COS45, 0, 0, S_ONE, S_ONE, S_ONE, 0, 0, 0));
    send_pose(make_pose(Q_COS45, 0, Q_COS45, 0, S_ONE, S_ONE, S_ONE, 0, 0, 0));
    send_pose(make_pose(Q_COS45, 0, 0, -Q_COS45, S_ONE, S_ONE, S_ONE, 0, 0, 0));
    send_pose(make_pose(0, Q_ONE, 0, 0, S_ONE, S_ONE, S_ONE, 0, 0, 0));
    send_pose(make_pose(0, 0, Q_ONE, 0, S_ONE, S_ONE, S_ONE, 0, 0, 0));
    send_pose(make_pose(0, 0, 0, Q_ONE, S_ONE, S_ONE, S_ONE, 0, 0, 0));
    // Negated identity gives the same rotation
    send_pose(make_pose(-Q_ONE, 0, 0, 0, S_ONE, S_ONE, S_ONE, 0, 0, 0));
  endtask

  task automatic test_scale_and_rounding();
    // Off-diagonal term lands exactly on half an LSB, both signs
    send_pose(make_pose(0, 128, 128, 0, 16, -16, 48, 0, 0, 0));
    send_pose(make_pose(0, -128, 128, 0, -16, 16, -48, 0, 0, 0));
    send_pose(make_pose(Q_COS45, 0, 0, Q_COS45, -S_ONE, 1, -1, 0, 0, 0));
    send_pose(make_pose(Q_COS45, Q_COS45, 0, 0, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0));
    send_pose(make_pose(Q_ONE, 0, 0, 0, 16'sh8000, 16'sh7FFF, -S_ONE, 0, 0, 0));
    send_pose(make_pose(8192, 8192, 8192, 8192, 3, 383, -129, 0, 0, 0));
  endtask

  task automatic test_translation();
    send_pose(make_pose(Q_ONE, 0, 0, 0, S_ONE, S_ONE, S_ONE,
                        32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    send_pose(make_pose(Q_ONE, 0, 0, 0, S_ONE, S_ONE, S_ONE,
                        -1, 32'sh5555_5555, 32'shAAAA_AAAA));
  endtask

  // Let the output run dry before carrying on
  task automatic test_drain_between_items();
    repeat (3) send_pose(random_unit_pose());
    drain_rows();
    send_pose(random_raw_pose());
    drain_rows();
  endtask

  task automatic test_burst_no_idle(input int count);
    idle_en = 1'b0;
    repeat (count) send_pose(random_unit_pose());
    idle_en = 1'b1;
  endtask

  task automatic test_random_poses(input int count);
    repeat (count) send_pose(random_unit_pose());
  endtask

  task automatic test_random_raw(input int count);
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) send_pose(random_unit_pose());
      else send_pose(random_raw_pose());
    end
  endtask

  // Result side: stall a random number of cycles after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end else if (out_valid && out_ready) begin
      rx_wait = idle_en ? $urandom_range(0, 5) : 0;
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name,
                                      input logic signed [31:0] exp_v,
                                      input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Compare every row transfer with the oldest queued row
  always @(posedge clk) begin
    matrix_row_t r;
    if (rst_n && out_valid && out_ready) begin
      if (row_q.size() == 0) begin
        $error("row %0d arrived with no row queued", out_row_index);
        err_count++;
      end else begin
        r = row_q.pop_front();
        check_field("out_row_index", 32'(r.idx), 32'(out_row_index));
        check_field("out_elem_0", r.e0, out_elem_0);
        check_field("out_elem_1", r.e1, out_elem_1);
        check_field("out_elem_2", r.e2, out_elem_2);
        check_field("out_saturated", 32'(r.sat), 32'(out_saturated));
        check_field("out_last_row", 32'(r.last), 32'(out_last_row));
        rows_checked++;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_identity_and_extremes();
    test_axis_rotations();
    test_scale_and_rounding();
    test_translation();
    test_drain_between_items();
    test_burst_no_idle(60);
    test_random_poses(110);
    test_random_raw(70);
    drain_rows();
    repeat (20) @(posedge clk);
    $display("%0d poses sent (axis turns, extremes, half-LSB rounding, unit and raw random),",
             items_sent);
    $display("%0d matrix rows checked under random stalls on both sides", rows_checked);
    if (err_count == 0) begin
      $display("tb_quaternion_trs_matrix: done, clean");
    end else begin
      $display("tb_quaternion_trs_matrix: done, errors");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #1_000_000;
    $display("tb_quaternion_trs_matrix: done, errors");
    $finish;
  end

endmodule
